// ===== src/spd_pkg.sv =====
// Shared constants, types and register codes for the stereo ping-pong delay.
// No dependencies; spd_cfg and stereo_pingpong_delay import this package.
package spd_pkg;

  // Line depth must be a power of two: tap addresses wrap by truncation.
  localparam int unsigned LINE_DEPTH = 65536;
  localparam int unsigned LINE_AW    = $clog2(LINE_DEPTH);

  localparam int unsigned SAMPLE_W  = 24;
  localparam int unsigned GAIN_W    = 17;
  localparam int unsigned DELAY_W   = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 32;

  localparam logic [GAIN_W-1:0] GAIN_ONE = 17'd65536;

  // Longest delay: (depth - 1) whole samples in Q16.16, capped at 32 bits.
  localparam logic [63:0] LIMIT_WIDE = (64'(LINE_DEPTH) - 64'd1) << 16;
  localparam logic [DELAY_W-1:0] DELAY_LIMIT =
    (LIMIT_WIDE > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : LIMIT_WIDE[31:0];

  localparam logic [DELAY_W-1:0] DELAY_RESET = 32'd629145600;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FB_GAIN     = 2'd0,
    REG_WET_MIX     = 2'd1,
    REG_SMOOTH_COEF = 2'd2,
    REG_DELAY_MIN   = 2'd3
  } cfg_reg_e;

  // Gains are held already capped at one.
  typedef struct packed {
    logic [GAIN_W-1:0]  fb_gain;
    logic [GAIN_W-1:0]  wet_mix;
    logic [GAIN_W-1:0]  smooth_coef;
    logic [DELAY_W-1:0] delay_min;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    fb_gain:     17'd32768,
    wet_mix:     17'd32768,
    smooth_coef: 17'd27,
    delay_min:   32'd15728640
  };

endpackage

// ===== src/spd_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module spd_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/spd_cfg.sv =====
// Configuration register file for the ping-pong delay; gains capped at one on write.
// Depends on spd_pkg.
module spd_cfg import spd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  output cfg_t                 cfg_o
);

  cfg_t              cfg_q, cfg_d;
  logic [GAIN_W-1:0] gain_wr;

  assign cfg_ready_o = 1'b1;
  assign gain_wr = (cfg_data_i[GAIN_W-1:0] > GAIN_ONE) ? GAIN_ONE : cfg_data_i[GAIN_W-1:0];

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_FB_GAIN:     cfg_d.fb_gain     = gain_wr;
        REG_WET_MIX:     cfg_d.wet_mix     = gain_wr;
        REG_SMOOTH_COEF: cfg_d.smooth_coef = gain_wr;
        REG_DELAY_MIN:   cfg_d.delay_min   = cfg_data_i[DELAY_W-1:0];
        default:         cfg_d             = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/stereo_pingpong_delay.sv =====
// Stereo ping-pong delay: clamp and smooth the delay, fractional tap read,
// cross feedback write-back and wet/dry mix. Depends on spd_pkg, spd_ram, spd_cfg.
//
//  channel   | direction | request moves                        | width
//  ----------+-----------+--------------------------------------+------
//  s_axis    | in        | dry_sample [23:0], delay_target [55:24] | 56
//  m_axis    | out       | left_sample [23:0], right_sample [47:24] | 48
//  cfg       | in        | register index, write data           | 2+32
//
//  One sample goes from acceptance to the output register through a sequencer of
//  states DIFF, MUL, STEP, RD0, RD1, DLT, LMUL, LSUM, FMUL and WR around the single
//  read port of each line. The next sample is accepted the cycle after the result
//  is registered; no new sample is taken while one is still in the sequencer.
//  The write-back step waits while the previous result is still held in the
//  output register. Reset needs no clearing pass: a fill pointer marks which
//  line entries were written, the rest read as zero.
module stereo_pingpong_delay import spd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [55:0]          s_axis_tdata,   // dry_sample [23:0], delay_target [55:24]
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [47:0]          m_axis_tdata,   // left_sample [23:0], right_sample [47:24]
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_DIFF = 4'd1;
  localparam logic [3:0] ST_MUL  = 4'd2;
  localparam logic [3:0] ST_STEP = 4'd3;
  localparam logic [3:0] ST_RD0  = 4'd4;
  localparam logic [3:0] ST_RD1  = 4'd5;
  localparam logic [3:0] ST_DLT  = 4'd6;
  localparam logic [3:0] ST_LMUL = 4'd7;
  localparam logic [3:0] ST_LSUM = 4'd8;
  localparam logic [3:0] ST_FMUL = 4'd9;
  localparam logic [3:0] ST_WR   = 4'd10;

  function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [26:0] v);
    logic signed [SAMPLE_W-1:0] r;
    if (v > 27'sd8388607) begin
      r = 24'sh7FFFFF;
    end else if (v < -27'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

  cfg_t cfg;

  logic [3:0]         state_q, state_d;
  logic [DELAY_W-1:0] cur_q, cur_d;
  logic [LINE_AW-1:0] wp_q, wp_d;
  logic               full_q, full_d;
  logic               m_valid_q, m_valid_d;

  logic signed [SAMPLE_W-1:0] dry_q;
  logic [DELAY_W-1:0]         tgt_q, diff_q;
  logic                       up_q;
  logic [48:0]                sprod_q;
  logic [LINE_AW-1:0]         p0_q;
  logic signed [23:0]         a_l_q, a_r_q, w_l_q, w_r_q;
  logic signed [24:0]         d_l_q, d_r_q, wd_l_q, wd_r_q;
  logic signed [41:0]         lp_l_q, lp_r_q, fbp_l_q, fbp_r_q;
  logic signed [42:0]         mxp_l_q, mxp_r_q;
  logic signed [23:0]         out_l_q, out_r_q;

  logic [DELAY_W-1:0]  in_target, tgt_lo, tgt_d;
  logic [49:0]         step_sum;
  logic [DELAY_W-1:0]  step;
  logic [LINE_AW-1:0]  p0_d, p1, raddr;
  logic                ok_a, ok_b, go, we;
  logic [SAMPLE_W-1:0] rd_l, rd_r, wdata_l, wdata_r;
  logic signed [16:0]  frac_s;
  logic signed [17:0]  fb_s, mix_s;
  logic signed [41:0]  lsum_l, lsum_r, fsum_l, fsum_r;
  logic signed [42:0]  msum_l, msum_r;
  logic signed [25:0]  lrnd_l, lrnd_r;

  spd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  spd_ram #(.WIDTH(SAMPLE_W), .DEPTH(LINE_DEPTH)) u_left_line (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (wp_q),
    .wdata_i (wdata_l),
    .raddr_i (raddr),
    .rdata_o (rd_l)
  );

  spd_ram #(.WIDTH(SAMPLE_W), .DEPTH(LINE_DEPTH)) u_right_line (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (wp_q),
    .wdata_i (wdata_r),
    .raddr_i (raddr),
    .rdata_o (rd_r)
  );

  // clamp: raise to the minimum first, then the line limit wins
  assign in_target = s_axis_tdata[55:24];
  assign tgt_lo    = (in_target < cfg.delay_min) ? cfg.delay_min : in_target;
  assign tgt_d     = (tgt_lo > DELAY_LIMIT) ? DELAY_LIMIT : tgt_lo;

  // rounded step never exceeds the distance, so no overshoot check
  assign step_sum = {1'b0, sprod_q} + 50'd32768;
  assign step     = step_sum[47:16];

  assign p0_d  = wp_q - LINE_AW'(cur_q[31:16]) - LINE_AW'(1);
  assign p1    = p0_q + LINE_AW'(1);
  assign raddr = (state_q == ST_RD0) ? p0_d : p1;
  // entries behind the fill pointer hold data; the rest still read as cleared
  assign ok_a  = full_q || (p0_q < wp_q);
  assign ok_b  = full_q || (p1 < wp_q);

  assign frac_s = $signed({1'b0, cur_q[15:0]});
  assign fb_s   = $signed({1'b0, cfg.fb_gain});
  assign mix_s  = $signed({1'b0, cfg.wet_mix});

  assign lsum_l = lp_l_q + 42'sd32768;
  assign lsum_r = lp_r_q + 42'sd32768;
  assign lrnd_l = $signed(lsum_l[41:16]);
  assign lrnd_r = $signed(lsum_r[41:16]);
  assign fsum_l = fbp_l_q + 42'sd32768;
  assign fsum_r = fbp_r_q + 42'sd32768;
  assign msum_l = mxp_l_q + 43'sd32768;
  assign msum_r = mxp_r_q + 43'sd32768;

  assign wdata_l = sat24(27'(dry_q) + 27'($signed(fsum_l[41:16])));
  assign wdata_r = sat24(27'(dry_q) + 27'($signed(fsum_r[41:16])));

  assign go = !m_valid_q || m_axis_tready;
  assign we = (state_q == ST_WR) && go;

  assign s_axis_tready = (state_q == ST_IDLE);

  always_comb begin
    state_d   = state_q;
    cur_d     = cur_q;
    wp_d      = wp_q;
    full_d    = full_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    unique case (state_q)
      ST_IDLE: if (s_axis_tvalid) state_d = ST_DIFF;
      ST_DIFF: state_d = ST_MUL;
      ST_MUL:  state_d = ST_STEP;
      ST_STEP: begin
        cur_d   = up_q ? cur_q + step : cur_q - step;
        state_d = ST_RD0;
      end
      ST_RD0:  state_d = ST_RD1;
      ST_RD1:  state_d = ST_DLT;
      ST_DLT:  state_d = ST_LMUL;
      ST_LMUL: state_d = ST_LSUM;
      ST_LSUM: state_d = ST_FMUL;
      ST_FMUL: state_d = ST_WR;
      ST_WR: begin
        if (go) begin
          wp_d      = wp_q + LINE_AW'(1);
          full_d    = full_q || (wp_q == LINE_AW'(LINE_DEPTH - 1));
          m_valid_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cur_q     <= DELAY_RESET;
      wp_q      <= '0;
      full_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cur_q     <= cur_d;
      wp_q      <= wp_d;
      full_q    <= full_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      dry_q <= $signed(s_axis_tdata[23:0]);
      tgt_q <= tgt_d;
    end
    if (state_q == ST_DIFF) begin
      up_q   <= (tgt_q >= cur_q);
      diff_q <= (tgt_q >= cur_q) ? tgt_q - cur_q : cur_q - tgt_q;
    end
    if (state_q == ST_MUL) begin
      sprod_q <= 49'(diff_q) * 49'(cfg.smooth_coef);
    end
    if (state_q == ST_RD0) begin
      p0_q <= p0_d;
    end
    if (state_q == ST_RD1) begin
      a_l_q <= ok_a ? $signed(rd_l) : '0;
      a_r_q <= ok_a ? $signed(rd_r) : '0;
    end
    if (state_q == ST_DLT) begin
      d_l_q <= (ok_b ? 25'($signed(rd_l)) : 25'sd0) - 25'(a_l_q);
      d_r_q <= (ok_b ? 25'($signed(rd_r)) : 25'sd0) - 25'(a_r_q);
    end
    if (state_q == ST_LMUL) begin
      lp_l_q <= d_l_q * frac_s;
      lp_r_q <= d_r_q * frac_s;
    end
    if (state_q == ST_LSUM) begin
      w_l_q  <= 24'(26'(a_l_q) + lrnd_l);
      w_r_q  <= 24'(26'(a_r_q) + lrnd_r);
      wd_l_q <= 25'(26'(a_l_q) + lrnd_l - 26'(dry_q));
      wd_r_q <= 25'(26'(a_r_q) + lrnd_r - 26'(dry_q));
    end
    if (state_q == ST_FMUL) begin
      // ping-pong: each line is fed from the opposite tap
      fbp_l_q <= w_r_q * fb_s;
      fbp_r_q <= w_l_q * fb_s;
      mxp_l_q <= wd_l_q * mix_s;
      mxp_r_q <= wd_r_q * mix_s;
    end
    if (we) begin
      out_l_q <= sat24(27'(dry_q) + $signed(msum_l[42:16]));
      out_r_q <= sat24(27'(dry_q) + $signed(msum_r[42:16]));
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {out_r_q, out_l_q};

endmodule
